[rtl/ippk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ippk_pkg
// Shared constants, codes and types of the indexed pixel format packer.
// ----------------------------------------------------------------------------
package ippk_pkg;

	localparam int unsigned PAL_ENTRIES_DEF = 256;
	localparam int unsigned MAX_WIDTH_DEF   = 4096;

	localparam int unsigned IDX_W     = 8;
	localparam int unsigned CHAN_W    = 16;
	localparam int unsigned RGB_W     = 3 * CHAN_W;
	localparam int unsigned MAP_W     = 8;
	localparam int unsigned MASK_W    = 32;
	localparam int unsigned IMG_W_W   = 13;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned S_DATA_W  = 64;
	localparam int unsigned GRP_BYTES = 5;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned POS_W     = 3;

	// depth modes
	localparam logic [MODE_W-1:0] MODE_BYTE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PACK1 = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PACK2 = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PACK4 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RGB16 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RGB24 = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MSB     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STIPPLE = 3'd6;

	// item kinds
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// byte group kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_RGB16 = 2'd1;
	localparam logic [1:0] KIND_RGB24 = 2'd2;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [RGB_W-1:0] rgb;
		logic [MAP_W-1:0] map;
	} pal_wr_t;

	typedef struct packed {
		logic [GRP_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      row_end;
	} group_t;

endpackage
`default_nettype wire

[rtl/indexed_pixel_format_packer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_pixel_format_packer
// Maps indexed pixels through a palette and emits packed bytes in the
// configured target pixel format.
// Throughput: one item per cycle for loads, depth 8 and most packed pixels
// while the output is not stalled; otherwise items wait while the byte-wide
// output sequencer sends each pixel's bytes (2 for depth 16, 4 for depth 24,
// up to 5 at a packed row end).
// Reset: asynchronous; sets configuration registers to defaults and resets the
// valid flags and stream state, palette contents are undefined until loaded.
// ----------------------------------------------------------------------------
module indexed_pixel_format_packer import ippk_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF,
	parameter int unsigned MAX_WIDTH       = MAX_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// entry_index, red, green, blue, mapped_value
	input  wire logic [S_DATA_W-1:0]  s_axis_tdata,
	// operation, first_pixel
	input  wire logic [1:0]           s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [7:0]                m_axis_tdata,  // out_byte
	output logic [0:0]                m_axis_tuser,  // last_of_item
	output logic                      m_axis_tlast,  // end_of_row
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned CMPW = CW + 1;

	function automatic logic [5:0] top_bit(input logic [MASK_W-1:0] m);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (m[i]) begin
				r = {1'b1, 5'(i)};
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] chan16(input logic [15:0] c, input logic [5:0] tb);
		logic [31:0] wide;
		wide = '0;
		if (tb[5]) begin
			if (tb[4:0] >= 5'd15) begin
				wide = {16'b0, c} << (tb[4:0] - 5'd15);
			end else begin
				wide = {16'b0, c >> (5'd15 - tb[4:0])};
			end
		end
		return wide[15:0];
	endfunction

	function automatic logic [31:0] chan24(input logic [7:0] c, input logic [5:0] tb);
		logic [31:0] wide;
		wide = '0;
		if (tb[5]) begin
			if (tb[4:0] >= 5'd7) begin
				wide = {24'b0, c} << (tb[4:0] - 5'd7);
			end else begin
				wide = {24'b0, c >> (5'd7 - tb[4:0])};
			end
		end
		return wide;
	endfunction

	// configuration
	logic [MODE_W-1:0]  depth_q;
	logic               msb_q;
	logic [MASK_W-1:0]  red_q, green_q, blue_q;
	logic [IMG_W_W-1:0] width_q;
	logic               stip_en_q;
	logic [5:0]         top_r_q, top_g_q, top_b_q;

	// stream state
	logic [CW-1:0] col_q;
	logic          lin_q, row_q;
	logic [7:0]    stip_q, part_q;
	logic [2:0]    bpos_q;

	// pipeline
	logic             valid_s1, first_s1;
	logic             valid_s2, row_end_s2;
	logic [1:0]       kind_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [7:0]       byte_s2;

	logic             in_acc, in_op, in_first;
	logic             adv1, adv2, s1_free, s2_free;
	pal_wr_t          pal_wr;
	logic [MAP_W-1:0] map_val;
	logic [RGB_W-1:0] rgb_val;
	group_t           grp;
	logic             grp_valid, grp_ready;

	// stage 1 logic
	logic             pack;
	logic [1:0]       ld;
	logic [2:0]       start, b_e, m_steps, rr, step_r, nsh, new_b, bpos_d;
	logic [7:0]       p_e, stip_e, v, pn, part_d;
	logic [CW-1:0]    col_e, col_d;
	logic             lin_e, row_e, row_end, done;
	logic [14:0]      shifted;
	logic [CMPW-1:0]  w_e;
	logic [3:0]       pad, nsteps, rest;
	logic [CNT_W-1:0] ecnt, cnt_d;
	logic [1:0]       kind_d;

	// stage 2 logic
	logic [15:0] t16;
	logic [31:0] t24;

	assign in_op    = s_axis_tuser[0];
	assign in_first = s_axis_tuser[1];
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	assign adv2          = valid_s2 && ((cnt_s2 == '0) || grp_ready);
	assign s2_free       = !valid_s2 || adv2;
	assign adv1          = valid_s1 && s2_free;
	assign s1_free       = !valid_s1 || adv1;
	assign s_axis_tready = s1_free;
	assign cfg_ready     = 1'b1;

	always_comb begin
		pal_wr.en   = in_acc && (in_op == OP_LOAD);
		pal_wr.addr = s_axis_tdata[7:0];
		pal_wr.rgb  = {s_axis_tdata[23:8], s_axis_tdata[39:24], s_axis_tdata[55:40]};
		pal_wr.map  = s_axis_tdata[63:56];
	end

	ippk_palette #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk        (clk),
		.wr         (pal_wr),
		.map_rd_en  (in_acc && (in_op == OP_PIXEL)),
		.map_rd_addr(s_axis_tdata[7:0]),
		.map_rd_data(map_val),
		.rgb_rd_en  (adv1),
		.rgb_rd_addr(v),
		.rgb_rd_data(rgb_val)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= MODE_BYTE;
			msb_q     <= 1'b1;
			red_q     <= 32'h0000_f800;
			green_q   <= 32'h0000_07e0;
			blue_q    <= 32'h0000_001f;
			width_q   <= 13'd64;
			stip_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEPTH:   depth_q   <= cfg_data[MODE_W-1:0];
				REG_MSB:     msb_q     <= cfg_data[0];
				REG_RED:     red_q     <= cfg_data;
				REG_GREEN:   green_q   <= cfg_data;
				REG_BLUE:    blue_q    <= cfg_data;
				REG_WIDTH:   width_q   <= cfg_data[IMG_W_W-1:0];
				REG_STIPPLE: stip_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// highest set bit of each channel mask
	always_ff @(posedge clk) begin
		top_r_q <= top_bit(red_q);
		top_g_q <= top_bit(green_q);
		top_b_q <= top_bit(blue_q);
	end

	// stage 1: map, stipple, packing arithmetic
	always_comb begin
		pack = (depth_q == MODE_PACK1) || (depth_q == MODE_PACK2) ||
			(depth_q == MODE_PACK4);
		if (depth_q == MODE_PACK2) begin
			ld = 2'd1;
		end else if (depth_q == MODE_PACK4) begin
			ld = 2'd2;
		end else begin
			ld = 2'd0;
		end
		start = msb_q ? 3'(4'd8 - (4'd1 << ld)) : 3'd0;

		b_e    = first_s1 ? start : bpos_q;
		p_e    = first_s1 ? 8'd0 : part_q;
		col_e  = first_s1 ? '0 : col_q;
		lin_e  = first_s1 ? 1'b0 : lin_q;
		row_e  = first_s1 ? 1'b0 : row_q;
		stip_e = first_s1 ? map_val : stip_q;

		v = (stip_en_q && ((lin_e ^ row_e) == 1'b0)) ? stip_e : map_val;
		shifted = {7'b0, v} << b_e;
		pn = p_e | shifted[7:0];

		if (width_q == '0) begin
			w_e = CMPW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_e = CMPW'(MAX_WIDTH);
		end else begin
			w_e = CMPW'(width_q);
		end
		row_end = (CMPW'(col_e) + CMPW'(1)) >= w_e;
		col_d   = row_end ? '0 : (col_e + CW'(1));

		pad     = 4'd8 - {1'b0, w_e[2:0]};
		nsteps  = 4'd1 + (row_end ? pad : 4'd0);
		m_steps = msb_q ? (b_e >> ld) : ((3'd7 - b_e) >> ld);
		done    = nsteps > {1'b0, m_steps};
		rest    = nsteps - {1'b0, m_steps} - 4'd1;
		ecnt    = done ? CNT_W'(4'd1 + (rest >> (2'd3 - ld))) : '0;
		rr      = rest[2:0] & 3'(4'd7 >> ld);
		step_r  = rr << ld;
		nsh     = 3'(nsteps) << ld;
		if (done) begin
			new_b = msb_q ? (start - step_r) : (start + step_r);
		end else begin
			new_b = msb_q ? (b_e - nsh) : (b_e + nsh);
		end
		bpos_d = pack ? new_b : b_e;
		part_d = (pack && done) ? 8'd0 : (pack ? pn : p_e);

		case (depth_q)
			MODE_BYTE: begin
				cnt_d  = CNT_W'(1);
				kind_d = KIND_BYTE;
			end
			MODE_PACK1, MODE_PACK2, MODE_PACK4: begin
				cnt_d  = ecnt;
				kind_d = KIND_BYTE;
			end
			MODE_RGB16: begin
				cnt_d  = CNT_W'(2);
				kind_d = KIND_RGB16;
			end
			MODE_RGB24: begin
				cnt_d  = CNT_W'(4);
				kind_d = KIND_RGB24;
			end
			default: begin
				cnt_d  = '0;
				kind_d = KIND_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			col_q    <= '0;
			lin_q    <= 1'b0;
			row_q    <= 1'b0;
			stip_q   <= '0;
			part_q   <= '0;
			bpos_q   <= 3'd7;
		end else begin
			if (in_acc && (in_op == OP_PIXEL)) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv1) begin
				col_q  <= col_d;
				lin_q  <= ~lin_e;
				row_q  <= row_end ? ~row_e : row_e;
				stip_q <= stip_e;
				part_q <= part_d;
				bpos_q <= bpos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_op == OP_PIXEL)) begin
			first_s1 <= in_first;
		end
		if (adv1) begin
			cnt_s2     <= cnt_d;
			kind_s2    <= kind_d;
			byte_s2    <= pack ? pn : v;
			row_end_s2 <= row_end;
		end
	end

	// stage 2: place palette rgb by the channel masks, or pass the packed byte
	always_comb begin
		t16 = (chan16(rgb_val[47:32], top_r_q) & red_q[15:0]) |
			(chan16(rgb_val[31:16], top_g_q) & green_q[15:0]) |
			(chan16(rgb_val[15:0], top_b_q) & blue_q[15:0]);
		t24 = chan24(rgb_val[47:40], top_r_q) |
			chan24(rgb_val[31:24], top_g_q) |
			chan24(rgb_val[15:8], top_b_q);

		grp.bytes   = '0;
		grp.count   = cnt_s2;
		grp.row_end = row_end_s2;
		case (kind_s2)
			KIND_RGB16: begin
				grp.bytes[0] = msb_q ? t16[15:8] : t16[7:0];
				grp.bytes[1] = msb_q ? t16[7:0] : t16[15:8];
			end
			KIND_RGB24: begin
				grp.bytes[0] = msb_q ? t24[31:24] : t24[7:0];
				grp.bytes[1] = msb_q ? t24[23:16] : t24[15:8];
				grp.bytes[2] = msb_q ? t24[15:8] : t24[23:16];
				grp.bytes[3] = msb_q ? t24[7:0] : t24[31:24];
			end
			default: begin
				grp.bytes[0] = byte_s2;
			end
		endcase
	end

	assign grp_valid = valid_s2 && (cnt_s2 != '0);

	ippk_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_valid    (grp_valid),
		.grp_ready    (grp_ready),
		.grp          (grp),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |-> !s_axis_tready)
		else $error("item taken while stage 1 is held");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 <= CNT_W'(GRP_BYTES)))
		else $error("byte group larger than five");

	a_rgb24_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (kind_s2 == KIND_RGB24)) |-> (cnt_s2 == CNT_W'(4)))
		else $error("depth 24 pixel without four bytes");

	a_first_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && first_s1) |=> (lin_q && !$past(row_end) ? (row_q == 1'b0) : 1'b1))
		else $error("first pixel did not restart stream state");

endmodule
`default_nettype wire

[rtl/ippk_palette.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ippk_palette
// Palette store: index map and 48-bit rgb, one write and one read port each,
// registered reads, out-of-range reads return zero.
// ----------------------------------------------------------------------------
module ippk_palette import ippk_pkg::*; #(
	parameter int unsigned ENTRIES = PAL_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire pal_wr_t          wr,
	input  wire logic             map_rd_en,
	input  wire logic [IDX_W-1:0] map_rd_addr,
	output logic      [MAP_W-1:0] map_rd_data,
	input  wire logic             rgb_rd_en,
	input  wire logic [IDX_W-1:0] rgb_rd_addr,
	output logic      [RGB_W-1:0] rgb_rd_data
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(ENTRIES);

	logic [MAP_W-1:0] map_mem [ENTRIES];
	logic [RGB_W-1:0] rgb_mem [ENTRIES];

	logic [MAP_W-1:0] map_q;
	logic             map_ok_q;
	logic [RGB_W-1:0] rgb_q;
	logic             rgb_ok_q;
	logic             wr_ok;

	assign wr_ok = wr.en && ({1'b0, wr.addr} < LIMIT);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			map_mem[wr.addr[AW-1:0]] <= wr.map;
		end
		if (map_rd_en) begin
			map_q    <= map_mem[map_rd_addr[AW-1:0]];
			map_ok_q <= ({1'b0, map_rd_addr} < LIMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			rgb_mem[wr.addr[AW-1:0]] <= wr.rgb;
		end
		if (rgb_rd_en) begin
			rgb_q    <= rgb_mem[rgb_rd_addr[AW-1:0]];
			rgb_ok_q <= ({1'b0, rgb_rd_addr} < LIMIT);
		end
	end

	assign map_rd_data = map_ok_q ? map_q : '0;
	assign rgb_rd_data = rgb_ok_q ? rgb_q : '0;

endmodule
`default_nettype wire

[rtl/ippk_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ippk_emit
// Output sequencer: holds one group of up to five bytes, sends one item per
// cycle while m_axis_tready is high and flags the last byte of group and row.
// ----------------------------------------------------------------------------
module ippk_emit import ippk_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       grp_valid,
	output logic            grp_ready,
	input  wire group_t     grp,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // out_byte
	output logic [0:0]      m_axis_tuser,  // last_of_item
	output logic            m_axis_tlast
);

	group_t           grp_q;
	logic [POS_W-1:0] pos_q;
	logic             busy_q;
	logic             last;

	assign last          = (pos_q == (grp_q.count - CNT_W'(1)));
	assign grp_ready     = !busy_q || (m_axis_tready && last);
	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = grp_q.bytes[pos_q];
	assign m_axis_tuser  = last;
	assign m_axis_tlast  = last && grp_q.row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (grp_valid && grp_ready) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q && m_axis_tready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			grp_q <= grp;
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q < grp_q.count))
		else $error("byte position beyond group");

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_valid && grp_ready) |-> (grp.count != '0))
		else $error("empty byte group taken");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !m_axis_tready) |=> (busy_q && $stable(pos_q)))
		else $error("group lost while stalled");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed pixel format packer. Palette loads and
// pixel items go in on the input stream under many register settings; a
// predictor of the mapping, stipple, bit packing, row padding and RGB
// placement builds the bytes each pixel should give. A checker compares every
// output item with the oldest expected byte while both sides idle at random.
// ----------------------------------------------------------------------------
module tb import ippk_pkg::*; ();

	localparam logic [MODE_W-1:0] MODE_NONE  = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
	localparam int unsigned MAX_BYTES   = 5;
	localparam int unsigned TAIL_CYCLES = 12;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [MAP_W-1:0]  map;
		logic              first;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       row_end;
	} out_byte_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata;   // entry_index, red, green, blue, mapped_value
	logic [1:0]           s_axis_tuser;   // operation, first_pixel
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;   // out_byte
	logic [0:0]           m_axis_tuser;   // last_of_item
	logic                 m_axis_tlast;   // end_of_row
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	indexed_pixel_format_packer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	logic [RGB_W-1:0]   pal_rgb [256];
	logic [MAP_W-1:0]   pal_map [256];
	bit                 pal_written [256];
	int unsigned        col_count;
	bit                 lin_par;
	bit                 row_par;
	logic [7:0]         stip_color;
	logic [7:0]         part_byte;
	int unsigned        bit_pos;

	logic [MODE_W-1:0]  cfg_depth;
	bit                 cfg_msb;
	logic [MASK_W-1:0]  cfg_red;
	logic [MASK_W-1:0]  cfg_green;
	logic [MASK_W-1:0]  cfg_blue;
	logic [IMG_W_W-1:0] cfg_width;
	bit                 cfg_stipple;

	out_byte_t expected_bytes[$];
	out_byte_t item_bytes[$];
	int        error_count;
	bit        no_gaps;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned bits_per_pixel();
		case (cfg_depth)
			MODE_PACK2: return 2;
			MODE_PACK4: return 4;
			default:    return 1;
		endcase
	endfunction

	function automatic int unsigned start_pos();
		return cfg_msb ? 8 - bits_per_pixel() : 0;
	endfunction

	function automatic int top_bit(logic [31:0] m);
		for (int i = 31; i >= 0; i--)
			if (m[i])
				return i;
		return -1;
	endfunction

	function automatic logic [63:0] shift_by(logic [63:0] x, int s);
		if (s >= 0)
			return (s >= 63) ? 64'd0 : x << s;
		return (-s >= 63) ? 64'd0 : x >> (-s);
	endfunction

	function automatic void push_byte(logic [7:0] b);
		out_byte_t r;
		r.data    = b;
		r.last    = 1'b0;
		r.row_end = 1'b0;
		if (item_bytes.size() < MAX_BYTES)
			item_bytes.push_back(r);
	endfunction

	// one pixel slot in the packing depths
	function automatic void advance_slot();
		int unsigned d;
		bit done;
		d = bits_per_pixel();
		if (cfg_msb) begin
			done = bit_pos < d;
			if (!done)
				bit_pos -= d;
		end else begin
			done = bit_pos + d >= 8;
			if (!done)
				bit_pos += d;
		end
		if (done) begin
			push_byte(part_byte);
			part_byte = 8'd0;
			bit_pos   = start_pos();
		end
	endfunction

	function automatic void compute_bytes(pix_item_t it);
		logic [7:0]  v;
		logic [15:0] wide;
		bit          row_end;
		int unsigned w;
		int unsigned pad;
		int          sh;
		logic [63:0] r;
		logic [63:0] g;
		logic [63:0] b;
		logic [63:0] t;
		out_byte_t   tail;
		if (it.op == OP_LOAD) begin
			pal_rgb[it.idx]     = {it.red, it.green, it.blue};
			pal_map[it.idx]     = it.map;
			pal_written[it.idx] = 1'b1;
			return;
		end
		item_bytes.delete();
		w = 32'(cfg_width);
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH_DEF)
			w = MAX_WIDTH_DEF;
		if (it.first) begin
			col_count  = 0;
			lin_par    = 1'b0;
			row_par    = 1'b0;
			part_byte  = 8'd0;
			bit_pos    = start_pos();
			stip_color = pal_map[it.idx];
		end
		v = pal_map[it.idx];
		if (cfg_stipple && ((lin_par ^ row_par) == 1'b0))
			v = stip_color;
		row_end = (col_count + 1 >= w);
		case (cfg_depth)
			MODE_BYTE: push_byte(v);
			MODE_PACK1, MODE_PACK2, MODE_PACK4: begin
				pad       = 8 - (w % 8);
				wide      = {8'd0, v} << bit_pos;
				part_byte = part_byte | wide[7:0];
				advance_slot();
				if (row_end)
					for (int k = 0; k < pad; k++)
						advance_slot();
			end
			MODE_RGB16, MODE_RGB24: begin
				r = {48'd0, pal_rgb[v][47:32]};
				g = {48'd0, pal_rgb[v][31:16]};
				b = {48'd0, pal_rgb[v][15:0]};
				if (cfg_depth == MODE_RGB16) begin
					t = (shift_by(r, top_bit(cfg_red) - 15) & {32'd0, cfg_red}) |
					    (shift_by(g, top_bit(cfg_green) - 15) & {32'd0, cfg_green}) |
					    (shift_by(b, top_bit(cfg_blue) - 15) & {32'd0, cfg_blue});
					if (cfg_msb) begin
						push_byte(t[15:8]);
						push_byte(t[7:0]);
					end else begin
						push_byte(t[7:0]);
						push_byte(t[15:8]);
					end
				end else begin
					t = shift_by({56'd0, r[15:8]}, top_bit(cfg_red) - 7) |
					    shift_by({56'd0, g[15:8]}, top_bit(cfg_green) - 7) |
					    shift_by({56'd0, b[15:8]}, top_bit(cfg_blue) - 7);
					for (int s = 0; s < 4; s++) begin
						sh = cfg_msb ? 24 - 8 * s : 8 * s;
						push_byte(t[sh +: 8]);
					end
				end
			end
			default: ;
		endcase
		lin_par = ~lin_par;
		if (row_end) begin
			col_count = 0;
			row_par   = ~row_par;
		end else begin
			col_count++;
		end
		if (item_bytes.size() > 0) begin
			tail      = item_bytes.pop_back();
			tail.last = 1'b1;
			if (row_end)
				tail.row_end = 1'b1;
			item_bytes.push_back(tail);
		end
		while (item_bytes.size() > 0)
			expected_bytes.push_back(item_bytes.pop_front());
	endfunction

	function automatic void reset_predictor();
		for (int i = 0; i < 256; i++)
			pal_written[i] = 1'b0;
		col_count   = 0;
		lin_par     = 1'b0;
		row_par     = 1'b0;
		stip_color  = 8'd0;
		part_byte   = 8'd0;
		bit_pos     = 7;
		cfg_depth   = MODE_BYTE;
		cfg_msb     = 1'b1;
		cfg_red     = 32'd63488;
		cfg_green   = 32'd2016;
		cfg_blue    = 32'd31;
		cfg_width   = 13'd64;
		cfg_stipple = 1'b0;
	endfunction

	// a colour index whose entry and mapped entry have both been loaded
	function automatic logic [7:0] pick_index();
		logic [7:0] i;
		for (int k = 0; k < 200; k++) begin
			i = 8'($urandom_range(0, 255));
			if (pal_written[i] && pal_written[pal_map[i]])
				return i;
		end
		return 8'h00;
	endfunction

	function automatic logic [31:0] random_mask();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hffff_ffff;
			2:       return 32'd1 << $urandom_range(0, 31);
			3:       return $urandom;
			4:       return 32'hff << $urandom_range(0, 24);
			default: return $urandom & 32'h0000_ffff;
		endcase
	endfunction

	function automatic logic [31:0] random_width();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'd8;
			2:       return 32'd16;
			3:       return $urandom_range(4097, 8191);
			4:       return 32'd4096;
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_item(input pix_item_t it);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.map, it.blue, it.green, it.red, it.idx};
		s_axis_tuser  <= {it.first, it.op};
		do @(posedge clk); while (!s_axis_tready);
		compute_bytes(it);
	endtask

	task automatic send_pixel(input logic [7:0] idx, input bit first);
		pix_item_t it;
		it.op    = OP_PIXEL;
		it.idx   = idx;
		it.red   = 16'($urandom);
		it.green = 16'($urandom);
		it.blue  = 16'($urandom);
		it.map   = 8'($urandom);
		it.first = first;
		send_item(it);
	endtask

	task automatic send_load(input logic [7:0] idx, input logic [15:0] red,
			input logic [15:0] green, input logic [15:0] blue,
			input logic [7:0] map, input bit first);
		pix_item_t it;
		it.op    = OP_LOAD;
		it.idx   = idx;
		it.red   = red;
		it.green = green;
		it.blue  = blue;
		it.map   = map;
		it.first = first;
		send_item(it);
	endtask

	// pixels may complete no byte, so allow the pipeline to empty as well
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_DEPTH:   cfg_depth   = data[MODE_W-1:0];
			REG_MSB:     cfg_msb     = data[0];
			REG_RED:     cfg_red     = data;
			REG_GREEN:   cfg_green   = data;
			REG_BLUE:    cfg_blue    = data;
			REG_WIDTH:   cfg_width   = data[IMG_W_W-1:0];
			REG_STIPPLE: cfg_stipple = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_palette_fill();
		send_load(8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
		send_load(8'hff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1);
		send_load(8'h55, 16'h8421, 16'hc3a5, 16'h5a3c, 8'haa, 1'b0);
		send_load(8'haa, 16'h7bde, 16'h1248, 16'hf00f, 8'h55, 1'b0);
		send_load(8'h0f, 16'h0f0f, 16'hf0f0, 16'h00ff, 8'hf0, 1'b0);
		send_load(8'hf0, 16'hfedc, 16'h0123, 16'h8000, 8'h0f, 1'b0);
	endtask

	task automatic test_byte_depth();
		write_reg(REG_DEPTH, 32'(MODE_BYTE));
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hff, 1'b0);
		send_pixel(8'h55, 1'b0);
	endtask

	task automatic test_packed_depths();
		// zero width acts as one pixel per row
		write_reg(REG_DEPTH, 32'(MODE_PACK1));
		write_reg(REG_MSB, 1);
		write_reg(REG_WIDTH, 0);
		send_pixel(8'haa, 1'b1);
		send_pixel(8'h0f, 1'b0);
		// oversized width is clamped
		write_reg(REG_DEPTH, 32'(MODE_PACK4));
		write_reg(REG_MSB, 0);
		write_reg(REG_WIDTH, 8191);
		send_pixel(8'hf0, 1'b1);
		send_pixel(8'hff, 1'b0);
	endtask

	task automatic test_rgb_depths();
		write_reg(REG_DEPTH, 32'(MODE_RGB16));
		write_reg(REG_MSB, 1);
		write_reg(REG_WIDTH, 64);
		write_reg(REG_RED, 32'h0000_f800);
		write_reg(REG_GREEN, 32'h0000_07e0);
		write_reg(REG_BLUE, 32'h0000_001f);
		send_pixel(8'hff, 1'b1);
		send_pixel(8'h55, 1'b0);
		// empty mask and masks reaching the top bit
		write_reg(REG_DEPTH, 32'(MODE_RGB24));
		write_reg(REG_MSB, 0);
		write_reg(REG_RED, 32'h0000_0000);
		write_reg(REG_GREEN, 32'hffff_ffff);
		write_reg(REG_BLUE, 32'h8000_0000);
		send_pixel(8'haa, 1'b0);
		send_pixel(8'h0f, 1'b0);
	endtask

	task automatic test_stipple();
		write_reg(REG_STIPPLE, 1);
		write_reg(REG_DEPTH, 32'(MODE_NONE));
		send_pixel(8'h55, 1'b1);
		send_pixel(8'hff, 1'b0);
		write_reg(REG_DEPTH, 32'(MODE_PACK2));
		write_reg(REG_MSB, 1);
		write_reg(REG_WIDTH, 2);
		send_pixel(8'hff, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'haa, 1'b0);
		write_reg(REG_DEPTH, 32'(MODE_SPARE));
		send_pixel(8'h0f, 1'b0);
		write_reg(REG_STIPPLE, 0);
	endtask

	task automatic test_random_streams();
		int unsigned pick;
		for (int chunk = 0; chunk < 8; chunk++) begin
			write_reg(REG_DEPTH, $urandom_range(0, 7));
			write_reg(REG_MSB, $urandom_range(0, 1));
			write_reg(REG_RED, random_mask());
			write_reg(REG_GREEN, random_mask());
			write_reg(REG_BLUE, random_mask());
			write_reg(REG_WIDTH, random_width());
			write_reg(REG_STIPPLE, 32'($urandom_range(0, 3) == 0));
			no_gaps = (chunk % 4 == 3);
			// mostly a fresh image, sometimes the old stream carries on
			if ($urandom_range(0, 3) != 0)
				send_pixel(pick_index(), 1'b1);
			repeat (31) begin
				pick = $urandom_range(0, 99);
				// a loaded entry always maps to an entry already loaded
				if (pick < 20)
					send_load(8'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), pick_index(), 1'($urandom_range(0, 1)));
				else
					send_pixel(pick_index(), pick < 25);
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin : rx_side
		out_byte_t   want;
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h", m_axis_tdata));
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata !== want.data)
					flag_error($sformatf("byte %02h, expected %02h", m_axis_tdata, want.data));
				if (m_axis_tuser[0] !== want.last)
					flag_error($sformatf("last_of_item %b, expected %b", m_axis_tuser[0],
						want.last));
				if (m_axis_tlast !== want.row_end)
					flag_error($sformatf("end_of_row %b, expected %b", m_axis_tlast,
						want.row_end));
			end
		end
	end

	initial begin
		#400000;
		$display("FAIL indexed_pixel_format_packer");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		error_count   = 0;
		no_gaps       = 1'b0;
		reset_predictor();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_palette_fill();
		test_byte_depth();
		test_packed_depths();
		test_rgb_depths();
		test_stipple();
		test_random_streams();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS indexed_pixel_format_packer");
		else
			$display("FAIL indexed_pixel_format_packer");
		$finish;
	end

endmodule

[indexed_pixel_format_packer.f]
rtl/ippk_pkg.sv
rtl/ippk_palette.sv
rtl/ippk_emit.sv
rtl/indexed_pixel_format_packer.sv
tb/tb.sv
